FILE: hdl/bvt_pkg.sv
// Shared types, constants and cell control bundle for the bounded vector table.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bvt_pkg;

   // table capacity and derived widths
   localparam int CAPACITY   = 1024;
   localparam int OFFSET_W   = 10;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 11;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

   // operation codes
   localparam logic [1:0] FUNC_APPEND         = 2'd0;
   localparam logic [1:0] FUNC_SWAP_REMOVE    = 2'd1;
   localparam logic [1:0] FUNC_ORDERED_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_READ           = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]          func;
      logic [OFFSET_W-1:0] offset;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic               wr_append;     // write value into the cell at count
      logic               shift_down;    // ordered remove: cells in [pos, last) take upper entry
      logic               wr_swap;       // cell at pos takes its collect register
      logic               inject;        // cell at src loads its entry into the collect chain
      logic               shift_collect; // collect chain moves one cell towards cell 0
      logic [POS_W-1:0]   pos;
      logic [POS_W-1:0]   last;
      logic [POS_W-1:0]   count;
      logic [POS_W-1:0]   src;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: hdl/bounded_vector_table.sv
// Bounded vector table: packed table of 32-bit handles with a live count.
// Append, ordered remove and any failed operation finish in the execute state; read
// and swap remove then wait in the move state while the collect chain moves one cell
// per cycle towards cell 0. busy stays high until the result cycle, so the next
// transfer may start in that cycle. Synchronous reset empties the table; entry
// contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module bounded_vector_table
   import bvt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   cell_ctrl_type      ctrl;
   logic [VALUE_W-1:0] entry_chain   [CAPACITY+1];
   logic [VALUE_W-1:0] collect_chain [CAPACITY+1];

   bvt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .ctrl         (ctrl),
      .head_collect (collect_chain[0])
   );

   // nothing above the top cell
   assign entry_chain[CAPACITY]   = '0;
   assign collect_chain[CAPACITY] = '0;

   // row of cells, each fed by its upper neighbour
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bvt_cell u_cell (
         .clock       (clock),
         .cell_idx    (POS_W'(i)),
         .ctrl        (ctrl),
         .up_entry    (entry_chain[i+1]),
         .up_collect  (collect_chain[i+1]),
         .entry_out   (entry_chain[i]),
         .collect_out (collect_chain[i])
      );
   end

endmodule

`default_nettype wire

FILE: hdl/bvt_cell.sv
// One table cell: holds a single entry and one stage of the collect chain.
// Depends on bvt_pkg for the control bundle and widths.
`timescale 1ns / 1ps
`default_nettype none

module bvt_cell
   import bvt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [POS_W-1:0]     cell_idx,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [VALUE_W-1:0]   up_entry,
   input  wire logic [VALUE_W-1:0]   up_collect,
   output logic      [VALUE_W-1:0]   entry_out,
   output logic      [VALUE_W-1:0]   collect_out
);

   logic [VALUE_W-1:0] entry_ff, entry_in;
   logic [VALUE_W-1:0] collect_ff, collect_in;

   // pick the entry's next value from append, ordered shift or swap fill
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.wr_append && (cell_idx == ctrl.count)) begin
         entry_in = ctrl.value;
      end else if (ctrl.shift_down && (cell_idx >= ctrl.pos) && (cell_idx < ctrl.last)) begin
         entry_in = up_entry;
      end else if (ctrl.wr_swap && (cell_idx == ctrl.pos)) begin
         entry_in = collect_ff;
      end
   end

   // load or advance the collect chain
   always_comb begin
      collect_in = collect_ff;
      if (ctrl.inject && (cell_idx == ctrl.src)) begin
         collect_in = entry_ff;
      end else if (ctrl.shift_collect) begin
         collect_in = up_collect;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff   <= entry_in;
      collect_ff <= collect_in;
   end

   assign entry_out   = entry_ff;
   assign collect_out = collect_ff;

endmodule

`default_nettype wire

FILE: hdl/bvt_ctrl.sv
// Sequencer: live count, request decode, collect-chain timing and result register.
// Depends on bvt_pkg; drives the cell row through cell_ctrl_type.
`timescale 1ns / 1ps
`default_nettype none

module bvt_ctrl
   import bvt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_data,
   output logic                    rsp_strobe,
   output rsp_type                 rsp_data,
   output cell_ctrl_type           ctrl,
   input  wire logic [VALUE_W-1:0] head_collect
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_MOVE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [POS_W-1:0]   steps_ff, steps_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]         pos;
   logic [POS_W-1:0]         cnt_ext;
   logic [POS_W-1:0]         last;
   logic                     full;

   assign pos     = POS_W'(req_ff.offset);
   assign cnt_ext = POS_W'(count_ff);
   assign last    = cnt_ext - POS_W'(1);
   assign full    = (count_ff == CNT_W'(CAPACITY));

   // decode the request, sequence the collect chain and build the result;
   // the count after the operation is reported in its low bits
   always_comb begin
      state_in          = state_ff;
      req_in            = req_ff;
      count_in          = count_ff;
      steps_in          = steps_ff;
      rsp_strobe_in     = 1'b0;
      rsp_data_in       = rsp_data_ff;

      ctrl               = '0;
      ctrl.pos           = pos;
      ctrl.last          = last;
      ctrl.count         = cnt_ext;
      ctrl.src           = pos;
      ctrl.value         = req_ff.value;

      unique case (state_ff)
         S_IDLE: begin
            // hold the request for the following cycle
            if (start) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            rsp_data_in.read_value = '0;
            rsp_data_in.status     = STATUS_OK;
            if (req_ff.func == FUNC_APPEND) begin
               rsp_strobe_in = 1'b1;
               if (full) begin
                  rsp_data_in.status = STATUS_FULL;
               end else begin
                  ctrl.wr_append = 1'b1;
                  count_in       = count_ff + CNT_W'(1);
               end
            end else if (pos >= cnt_ext) begin
               rsp_strobe_in      = 1'b1;
               rsp_data_in.status = STATUS_RANGE;
            end else if (req_ff.func == FUNC_ORDERED_REMOVE) begin
               rsp_strobe_in   = 1'b1;
               ctrl.shift_down = 1'b1;
               count_in        = count_ff - CNT_W'(1);
            end else if (req_ff.func == FUNC_READ) begin
               // move the entry at pos down to cell 0
               ctrl.inject = 1'b1;
               ctrl.src    = pos;
               steps_in    = pos;
               state_in    = S_MOVE;
            end else begin
               // move the last entry down to the hole
               ctrl.inject = 1'b1;
               ctrl.src    = last;
               steps_in    = last - pos;
               state_in    = S_MOVE;
            end
            rsp_data_in.count = COUNT_W'(count_in);
         end
         S_MOVE: begin
            if (steps_ff == '0) begin
               state_in               = S_IDLE;
               rsp_strobe_in          = 1'b1;
               rsp_data_in.status     = STATUS_OK;
               rsp_data_in.read_value = '0;
               if (req_ff.func == FUNC_READ) begin
                  rsp_data_in.read_value = head_collect;
               end else begin
                  ctrl.wr_swap = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
               end
               rsp_data_in.count = COUNT_W'(count_in);
            end else begin
               ctrl.shift_collect = 1'b1;
               steps_in           = steps_ff - POS_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire
